// ===== design/pid_regulator_antiwindup_top_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef PID_REGULATOR_ANTIWINDUP_TOP_ASSERT_SVH
`define PID_REGULATOR_ANTIWINDUP_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PIDAW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PIDAW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/pidaw_pkg.sv =====
`default_nettype none

package pidaw_pkg;

  localparam bit TRAPEZOID = 1'b1;

  localparam int Q_FRAC = 24;
  localparam int G_W    = 32;
  localparam int A_W    = 52;
  localparam int ACC_W  = A_W + 2;
  localparam int SUM_W  = ACC_W + 1;
  localparam int RES_W  = ACC_W + G_W - Q_FRAC;
  localparam int CNT_W  = $clog2(G_W);
  localparam int P_W    = 40;
  localparam int DN_W   = 42;
  localparam int ST_W   = 48;
  localparam int U_W    = 50;
  localparam int WIDE_W = 64;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'sd8388608);

  typedef enum logic [2:0] {
    REG_P_GAIN,
    REG_I_GAIN,
    REG_D_GAIN,
    REG_HALF_PERIOD,
    REG_DER_POLE,
    REG_OUT_MIN,
    REG_OUT_MAX,
    REG_AW_GAIN
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_P_DONE,
    S_MUL_I,
    S_I_DONE,
    S_T_LOAD,
    S_MUL_T,
    S_T_DONE,
    S_MUL_D,
    S_D_DONE,
    S_MUL_F,
    S_F_DONE,
    S_SUM,
    S_CLAMP,
    S_MUL_W,
    S_W_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic mul_step;
    logic mul_load;
    logic out_load;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== design/pid_regulator_antiwindup_top.sv =====
// Channel  Dir  Handshake                   Payload
// sample   in   sample_valid/sample_stall   error_sample[31:0]
// result   out  result_valid/result_stall   drive[31:0], clamped
// cfg      in   cfg_valid/cfg_ready         cfg_index[2:0], cfg_data[31:0]
//
// A sample is taken only while the sequencer is idle, and every product of it runs through one
// bit-serial multiplier, so the next sample waits until the anti-windup product is done.
// With the plain-sum integrator the trapezoid product is skipped.
// Reset is synchronous and clears the controller, the configuration and the loop state.
// A stalled result holds in its register while the next sample is processed; the sequencer
// waits only when a new result is ready and the previous one is still stalled.
`default_nettype none

module pid_regulator_antiwindup_top
  import pidaw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sample_valid,
  output logic             sample_stall,
  input  wire logic [31:0] error_sample,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [31:0]      drive,
  output logic             clamped,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [ST_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
    if (v > 64'sd140737488355327) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < -64'sd140737488355328) begin
      return 48'sh8000_0000_0000;
    end
    return v[ST_W-1:0];
  endfunction

  state_t state, state_next;
  ctrl_t  ctrl;

  logic signed [31:0] p_gain, i_gain, d_gain, der_pole, out_min, out_max, aw_gain;
  logic        [30:0] half_period;

  logic signed [31:0]   integ_prev_in, deriv_prev_in, windup_term;
  logic signed [ST_W-1:0] integ_out, deriv_out;

  logic signed [31:0]   e_reg, x_reg;
  logic signed [P_W-1:0]  p_term;
  logic signed [DN_W-1:0] d_num;
  logic signed [U_W-1:0]  u_reg;

  logic signed [A_W-1:0]   a_reg, ld_a;
  logic        [G_W-1:0]   g_sr, ld_g;
  logic signed [ACC_W-1:0] acc;
  logic        [G_W-1:Q_FRAC] low;
  logic        [CNT_W-1:0] cnt;
  logic signed [SUM_W-1:0] addend, step_sum;
  logic signed [RES_W-1:0] res;
  logic                    mul_last;

  logic accept, out_free, gt, lt;
  logic signed [31:0] lim;

  assign accept   = sample_valid && !ctrl.busy;
  assign out_free = !result_valid || !result_stall;
  assign mul_last = (cnt == CNT_W'(G_W - 1));

  assign sample_stall = ctrl.busy;
  assign cfg_ready    = !ctrl.busy;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_MUL_P;
      S_MUL_P:  if (mul_last) state_next = S_P_DONE;
      S_P_DONE: state_next = S_MUL_I;
      S_MUL_I:  if (mul_last) state_next = S_I_DONE;
      S_I_DONE: state_next = S_T_LOAD;
      S_T_LOAD: state_next = TRAPEZOID ? S_MUL_T : S_MUL_D;
      S_MUL_T:  if (mul_last) state_next = S_T_DONE;
      S_T_DONE: state_next = S_MUL_D;
      S_MUL_D:  if (mul_last) state_next = S_D_DONE;
      S_D_DONE: state_next = S_MUL_F;
      S_MUL_F:  if (mul_last) state_next = S_F_DONE;
      S_F_DONE: state_next = S_SUM;
      S_SUM:    state_next = S_CLAMP;
      S_CLAMP:  if (out_free) state_next = S_MUL_W;
      S_MUL_W:  if (mul_last) state_next = S_W_DONE;
      S_W_DONE: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.busy     = (state != S_IDLE);
    ctrl.mul_step = (state == S_MUL_P) || (state == S_MUL_I) || (state == S_MUL_T) ||
                    (state == S_MUL_D) || (state == S_MUL_F) || (state == S_MUL_W);
    ctrl.out_load = (state == S_CLAMP) && out_free;
    ctrl.mul_load = ((state == S_IDLE) && accept) || (state == S_P_DONE) ||
                    (state == S_T_LOAD) || (state == S_T_DONE) || (state == S_D_DONE) ||
                    ctrl.out_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign gt  = u_reg > U_W'(out_max);
  assign lt  = u_reg < U_W'(out_min);
  assign lim = gt ? out_max : (lt ? out_min : u_reg[31:0]);

  always_comb begin
    ld_a = '0;
    ld_g = '0;
    case (state)
      S_IDLE: begin
        ld_a = A_W'($signed(error_sample));
        ld_g = p_gain;
      end
      S_P_DONE: begin
        ld_a = A_W'(e_reg);
        ld_g = i_gain;
      end
      S_T_LOAD: begin
        if (TRAPEZOID) begin
          ld_a = A_W'(x_reg) + A_W'(integ_prev_in);
          ld_g = {1'b0, half_period};
        end else begin
          ld_a = A_W'(e_reg) - A_W'(deriv_prev_in);
          ld_g = d_gain;
        end
      end
      S_T_DONE: begin
        ld_a = A_W'(e_reg) - A_W'(deriv_prev_in);
        ld_g = d_gain;
      end
      S_D_DONE: begin
        ld_a = A_W'(deriv_out);
        ld_g = der_pole;
      end
      S_CLAMP: begin
        ld_a = A_W'(lim) - A_W'(u_reg);
        ld_g = aw_gain;
      end
      default: begin
        ld_a = '0;
        ld_g = '0;
      end
    endcase
  end

  // Serial-parallel multiplier: one multiplier bit per cycle, LSB first, the last bit
  // carries negative weight. The rounding bias is preloaded into the accumulator.
  always_comb begin
    addend = '0;
    if (g_sr[0]) begin
      addend = mul_last ? -SUM_W'(a_reg) : SUM_W'(a_reg);
    end
  end

  assign step_sum = SUM_W'(acc) + addend;
  assign res      = {acc, low};

  always_ff @(posedge clk) begin
    if (ctrl.mul_load) begin
      a_reg <= ld_a;
      g_sr  <= ld_g;
      acc   <= ROUND_BIAS;
      cnt   <= '0;
    end else if (ctrl.mul_step) begin
      acc  <= step_sum[SUM_W-1:1];
      low  <= {step_sum[0], low[G_W-1:Q_FRAC+1]};
      g_sr <= {1'b0, g_sr[G_W-1:1]};
      cnt  <= cnt + CNT_W'(1);
    end
    if (state == S_IDLE && accept) begin
      e_reg <= error_sample;
    end
    case (state)
      S_P_DONE: p_term <= res[P_W-1:0];
      S_I_DONE: x_reg  <= sat32(WIDE_W'(res) + WIDE_W'(windup_term));
      S_D_DONE: d_num  <= res[DN_W-1:0];
      S_SUM:    u_reg  <= U_W'(p_term) + U_W'(integ_out) + U_W'(deriv_out);
      default: begin
      end
    endcase
    if (ctrl.out_load) begin
      drive   <= lim;
      clamped <= gt || lt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_prev_in <= '0;
      integ_out     <= '0;
      deriv_prev_in <= '0;
      deriv_out     <= '0;
      windup_term   <= '0;
      result_valid  <= 1'b0;
    end else begin
      case (state)
        S_T_LOAD: begin
          if (!TRAPEZOID) begin
            integ_out     <= sat48(WIDE_W'(integ_out) + WIDE_W'(x_reg));
            integ_prev_in <= x_reg;
          end
        end
        S_T_DONE: begin
          integ_out     <= sat48(WIDE_W'(integ_out) + WIDE_W'(res));
          integ_prev_in <= x_reg;
        end
        S_F_DONE: begin
          deriv_out     <= sat48(WIDE_W'(d_num) - WIDE_W'(res));
          deriv_prev_in <= e_reg;
        end
        S_W_DONE: windup_term <= sat32(WIDE_W'(res));
        default: begin
        end
      endcase
      if (ctrl.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain      <= '0;
      i_gain      <= '0;
      d_gain      <= '0;
      half_period <= '0;
      der_pole    <= '0;
      out_min     <= 32'sh8000_0000;
      out_max     <= 32'sh7FFF_FFFF;
      aw_gain     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_P_GAIN:      p_gain      <= cfg_data;
        REG_I_GAIN:      i_gain      <= cfg_data;
        REG_D_GAIN:      d_gain      <= cfg_data;
        REG_HALF_PERIOD: half_period <= cfg_data[30:0];
        REG_DER_POLE:    der_pole    <= cfg_data;
        REG_OUT_MIN:     out_min     <= cfg_data;
        REG_OUT_MAX:     out_max     <= cfg_data;
        REG_AW_GAIN:     aw_gain     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/pidaw_checker.sv =====
`default_nettype none

`include "pid_regulator_antiwindup_top_assert.svh"

module pidaw_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        sample_valid,
  input wire logic        sample_stall,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [31:0] drive,
  input wire logic        clamped,
  input wire logic        cfg_ready
);

  `PIDAW_ASSERT_NXT(a_result_hold, result_valid && result_stall, result_valid && $stable(drive) && $stable(clamped), "stalled result changed")
  `PIDAW_ASSERT_NXT(a_busy_after_take, sample_valid && !sample_stall, sample_stall, "sample taken while still idle")
  `PIDAW_ASSERT_IMP(a_cfg_idle_only, 1'b1, cfg_ready == !sample_stall, "config port open while busy")
  `PIDAW_ASSERT_IMP(a_result_from_work, $rose(result_valid), sample_stall, "result appeared without work")

endmodule

bind pid_regulator_antiwindup_top pidaw_checker u_pidaw_checker (.*);

`default_nettype wire

// ===== test/pid_regulator_antiwindup_top_tb.sv =====
`timescale 1ns / 100ps

module pid_regulator_antiwindup_top_tb;
  import pidaw_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 64;

  typedef logic [31:0] reg_set_t [8];

  typedef struct packed {
    logic [31:0] drive;
    logic        clamped;
  } drive_result_t;

  class drive_scoreboard;
    logic signed [31:0] kp, ki, kd, pole, lo_limit, hi_limit, kaw;
    logic [30:0]        half_t;
    logic signed [31:0] integ_prev_x, prev_error, windup;
    logic signed [47:0] integ_acc, deriv_acc;
    drive_result_t      pending [$];
    int                 mismatches;

    function new();
      kp = '0;
      ki = '0;
      kd = '0;
      half_t = '0;
      pole = '0;
      lo_limit = 32'sh8000_0000;
      hi_limit = 32'sh7FFF_FFFF;
      kaw = '0;
      integ_prev_x = '0;
      prev_error = '0;
      windup = '0;
      integ_acc = '0;
      deriv_acc = '0;
      mismatches = 0;
    endfunction

    // Signal times Q8.24 gain, rounded half up back to Q16.16.
    static function longint round_mul(longint a, longint g);
      logic signed [127:0] wide;
      wide = 128'(a);
      wide = wide * 128'(g);
      wide = wide + 128'sd8388608;
      wide = wide >>> 24;
      return longint'(wide);
    endfunction

    static function longint saturate(longint v, int bits);
      longint top;
      top = (longint'(1) <<< (bits - 1)) - 1;
      if (v > top) return top;
      if (v < -top - 1) return -top - 1;
      return v;
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] data);
      case (idx)
        REG_P_GAIN: kp = data;
        REG_I_GAIN: ki = data;
        REG_D_GAIN: kd = data;
        REG_HALF_PERIOD: half_t = data[30:0];
        REG_DER_POLE: pole = data;
        REG_OUT_MIN: lo_limit = data;
        REG_OUT_MAX: hi_limit = data;
        REG_AW_GAIN: kaw = data;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [31:0] sample);
      longint e, x, u, lim;
      logic   clip;
      e = longint'($signed(sample));
      x = saturate(round_mul(e, ki) + windup, 32);
      if (TRAPEZOID)
        integ_acc = 48'(saturate(integ_acc + round_mul(x + integ_prev_x, longint'(half_t)),
                                 48));
      else
        integ_acc = 48'(saturate(integ_acc + x, 48));
      integ_prev_x = 32'(x);
      deriv_acc = 48'(saturate(round_mul(e - prev_error, kd) - round_mul(deriv_acc, pole),
                               48));
      prev_error = 32'(e);
      u = round_mul(e, kp) + integ_acc + deriv_acc;
      lim = u;
      clip = 1'b0;
      if (u > hi_limit) begin
        lim = hi_limit;
        clip = 1'b1;
      end else if (u < lo_limit) begin
        lim = lo_limit;
        clip = 1'b1;
      end
      windup = 32'(saturate(round_mul(lim - u, kaw), 32));
      pending.push_back('{drive: lim[31:0], clamped: clip});
    endfunction

    function void check_drive(logic [31:0] drive, logic clamped);
      drive_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with none expected: drive %h clamped %b", $time, drive, clamped);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (drive !== want.drive || clamped !== want.clamped) begin
        $display("%0t: mismatch: expected drive %h clamped %b, actual drive %h clamped %b",
                 $time, want.drive, want.clamped, drive, clamped);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  logic [31:0] error_sample = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] drive;
  logic        clamped;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic        stall_on = 1'b0;
  int          stall_hold = 0;
  int          quiet_cycles = 0;
  bit          gaps_on = 1'b0;

  drive_scoreboard sb = new();

  logic [31:0] nominal_errors [15] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
    32'h0000_8000, 32'hFFFF_8000, 32'h0050_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000
  };
  logic [31:0] extreme_errors [8] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
    32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF
  };

  pid_regulator_antiwindup_top u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .error_sample (error_sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .drive        (drive),
    .clamped      (clamped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 24);
    return $urandom_range(60, 400);
  endfunction

  function automatic logic [31:0] rand_gain(int bits);
    return $signed($urandom) >>> (32 - bits);
  endfunction

  function automatic logic [31:0] rand_error();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      case ($urandom_range(0, 4))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'hFFFF_FFFF;
        3: return 32'h7FFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    if (pick < 50) return $signed($urandom) >>> 13;
    if (pick < 80) return $signed($urandom) >>> 6;
    return $urandom;
  endfunction

  function automatic reg_set_t make_regs(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                                         logic [31:0] half, logic [31:0] fb,
                                         logic [31:0] lo, logic [31:0] hi, logic [31:0] aw);
    reg_set_t vals;
    vals[REG_P_GAIN] = p;
    vals[REG_I_GAIN] = i;
    vals[REG_D_GAIN] = d;
    vals[REG_HALF_PERIOD] = half;
    vals[REG_DER_POLE] = fb;
    vals[REG_OUT_MIN] = lo;
    vals[REG_OUT_MAX] = hi;
    vals[REG_AW_GAIN] = aw;
    return vals;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(reg_idx_t'(cfg_index), cfg_data);
      if (sample_valid && !sample_stall) sb.note_sample(error_sample);
      if (result_valid && !result_stall) sb.check_drive(drive, clamped);
    end
  end

  always @(posedge clk) begin
    if (rst || !stall_on) begin
      result_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      result_stall <= !result_stall;
      stall_hold <= result_stall ? $urandom_range(0, 12) : idle_len();
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic load_regs(input reg_set_t vals);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sample(input logic [31:0] e);
    int pause;
    sample_valid <= 1'b1;
    error_sample <= e;
    do @(posedge clk); while (sample_stall);
    if (gaps_on) begin
      pause = idle_len();
      if (pause != 0) begin
        sample_valid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
  endtask

  // The block still finishes the anti-windup product after its result transfer,
  // so the settle time lets it go idle before any register write.
  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input reg_set_t vals, input int count, input bit idling,
                           input bit push_up);
    load_regs(vals);
    stall_on <= idling;
    gaps_on = idling;
    repeat (count) begin
      if (push_up && $urandom_range(0, 99) < 97)
        send_sample($urandom_range(32'h0100_0000, 32'h7FFF_FFFF));
      else
        send_sample(rand_error());
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_regs(make_regs(32'h0100_0000, 32'h0080_0000, 32'h0200_0000, 32'h0080_0000,
                        32'hFFC0_0000, 32'hFF9C_0000, 32'h0064_0000, 32'h0040_0000));
    foreach (nominal_errors[k]) send_sample(nominal_errors[k]);
    drain();

    // Inverted extreme limits, saturating gains; bit 31 of the half period is dropped.
    load_regs(make_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    foreach (extreme_errors[k]) send_sample(extreme_errors[k]);
    drain();

    run_phase(make_regs(rand_gain(26), $urandom_range(0, 32'h0080_0000), rand_gain(26),
                        $urandom_range(32'h0040_0000, 32'h0100_0000), rand_gain(25),
                        32'hFFB0_0000, 32'h00C8_0000,
                        $urandom_range(32'h0040_0000, 32'h0100_0000)), 90, 1'b1, 1'b0);
    run_phase(make_regs(32'h8000_0000, rand_gain(28), 32'h8000_0000, 32'h0000_0000,
                        32'h7FFF_FFFF, 32'h0010_0000, 32'hFFF0_0000, 32'h8000_0000),
              60, 1'b1, 1'b0);
    run_phase(make_regs(rand_gain(25), $urandom_range(0, 32'h0020_0000), rand_gain(25),
                        $urandom_range(0, 32'h0080_0000), 32'h0000_0000,
                        32'hFFFF_0000, 32'h0001_0000,
                        $urandom_range(32'h0040_0000, 32'h0100_0000)), 55, 1'b0, 1'b0);
    run_phase(make_regs(rand_gain(25), $urandom_range(0, 32'h0020_0000), rand_gain(25),
                        $urandom_range(0, 32'h0080_0000), rand_gain(25),
                        32'hFFFF_0000, 32'h0001_0000,
                        $urandom_range(32'h0040_0000, 32'h0100_0000)), 55, 1'b1, 1'b0);
    // Long positive error run drives the integrator into its 48-bit limit.
    run_phase(make_regs(32'h0000_0000, 32'h7FFF_FFFF, rand_gain(26), 32'hFFFF_FFFF,
                        rand_gain(25), 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000),
              300, 1'b1, 1'b1);

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/pidaw_pkg.sv
design/pid_regulator_antiwindup_top.sv
design/pidaw_checker.sv
test/pid_regulator_antiwindup_top_tb.sv
